/* sv/alm_pkg.sv */
package alm_pkg;

    // Command codes carried by a request.
    typedef enum logic [2:0] {
        CMD_READ         = 3'd0,
        CMD_WRITE        = 3'd1,
        CMD_APPEND       = 3'd2,
        CMD_REMOVE       = 3'd3,
        CMD_REMOVE_VALUE = 3'd4
    } cmd_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Controller sequencing states.
    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_RDWAIT,
        FSM_SEARCH,
        FSM_SHIFT,
        FSM_FINISH
    } fsm_t;

    // Fixed port widths of the result fields.
    localparam int unsigned POS_BITS   = 8;
    localparam int unsigned OWORD_BITS = 32;
    localparam int unsigned COUNT_BITS = 9;

    // One result as handed from the controller to the output register.
    typedef struct packed {
        status_t                 status;
        logic [OWORD_BITS-1:0]   word;
        logic [COUNT_BITS-1:0]   count;
    } result_t;

endpackage

/* sv/alm_store.sv */
module alm_store #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Single read port with registered data; the data holds between reads.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/alm_ctrl.sv */
module alm_ctrl #(
    parameter int unsigned CAPACITY  = 256,
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned AW        = 8,
    parameter int unsigned CW        = 9
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        command,
    input  logic [alm_pkg::POS_BITS-1:0]      position,
    input  logic [WORD_BITS-1:0]              word,
    output logic                              mem_wr_en,
    output logic [AW-1:0]                     mem_wr_addr,
    output logic [WORD_BITS-1:0]              mem_wr_data,
    output logic                              mem_rd_en,
    output logic [AW-1:0]                     mem_rd_addr,
    input  logic [WORD_BITS-1:0]              mem_rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output alm_pkg::result_t                  res
);

    // Width wide enough to compare a position against the length.
    localparam int unsigned PW = (CW > alm_pkg::POS_BITS) ? CW : alm_pkg::POS_BITS;

    alm_pkg::fsm_t    state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    tag_reg, tag_next;
    logic             pend_reg, pend_next;
    logic [WORD_BITS-1:0] key_reg, key_next;
    alm_pkg::status_t status_reg, status_next;
    logic [WORD_BITS-1:0] rdw_reg, rdw_next;

    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    cnt_ext;
    logic             in_range;
    logic             match;
    logic [63:0]      rdw_wide;
    logic [31:0]      cnt_wide;

    assign pos_ext  = PW'(position);
    assign cnt_ext  = PW'(count_reg);
    assign in_range = (pos_ext < cnt_ext);
    assign match    = pend_reg && (mem_rd_data == key_reg);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alm_pkg::FSM_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        tag_reg    <= tag_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rdw_reg    <= rdw_next;
    end

    // Sequencer: dispatch, read wait, value search, gap closing, hand-off.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        tag_next    = tag_reg;
        pend_next   = pend_reg;
        key_next    = key_reg;
        status_next = status_reg;
        rdw_next    = rdw_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = word;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            alm_pkg::FSM_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next    = word;
                    rdw_next    = '0;
                    status_next = alm_pkg::ST_OK;
                    pend_next   = 1'b0;
                    state_next  = alm_pkg::FSM_FINISH;
                    case (alm_pkg::cmd_t'(command))
                        alm_pkg::CMD_READ: begin
                            if (in_range) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = pos_ext[AW-1:0];
                                state_next  = alm_pkg::FSM_RDWAIT;
                            end else begin
                                status_next = alm_pkg::ST_RANGE;
                            end
                        end
                        alm_pkg::CMD_WRITE: begin
                            if (in_range) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = pos_ext[AW-1:0];
                            end else begin
                                status_next = alm_pkg::ST_RANGE;
                            end
                        end
                        alm_pkg::CMD_APPEND: begin
                            if (count_reg < CW'(CAPACITY)) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[AW-1:0];
                                count_next  = count_reg + 1'b1;
                            end else begin
                                status_next = alm_pkg::ST_FULL;
                            end
                        end
                        alm_pkg::CMD_REMOVE: begin
                            if (in_range) begin
                                idx_next   = pos_ext[CW-1:0] + 1'b1;
                                state_next = alm_pkg::FSM_SHIFT;
                            end else begin
                                status_next = alm_pkg::ST_RANGE;
                            end
                        end
                        alm_pkg::CMD_REMOVE_VALUE: begin
                            idx_next   = '0;
                            state_next = alm_pkg::FSM_SEARCH;
                        end
                        default: begin
                            status_next = alm_pkg::ST_RANGE;
                        end
                    endcase
                end
            end

            alm_pkg::FSM_RDWAIT: begin
                rdw_next   = mem_rd_data;
                state_next = alm_pkg::FSM_FINISH;
            end

            // One read per cycle; each word is compared the cycle after its read.
            alm_pkg::FSM_SEARCH: begin
                if (match) begin
                    idx_next   = CW'(tag_reg) + 1'b1;
                    pend_next  = 1'b0;
                    state_next = alm_pkg::FSM_SHIFT;
                end else if (idx_reg < count_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[AW-1:0];
                    tag_next    = idx_reg[AW-1:0];
                    idx_next    = idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    pend_next   = 1'b0;
                    status_next = alm_pkg::ST_MISSING;
                    state_next  = alm_pkg::FSM_FINISH;
                end
            end

            // Read entry k+1 while writing the word read last cycle, from entry k, to entry k-1.
            alm_pkg::FSM_SHIFT: begin
                if (pend_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = tag_reg;
                    mem_wr_data = mem_rd_data;
                end
                if (idx_reg < count_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[AW-1:0];
                    tag_next    = idx_reg[AW-1:0] - 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - 1'b1;
                    state_next = alm_pkg::FSM_FINISH;
                end
            end

            alm_pkg::FSM_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = alm_pkg::FSM_IDLE;
                end
            end

            default: begin
                state_next = alm_pkg::FSM_IDLE;
            end
        endcase
    end

    // Result fields at the port widths.
    assign rdw_wide   = 64'(rdw_reg);
    assign cnt_wide   = 32'(count_reg);
    assign res.status = status_reg;
    assign res.word   = rdw_wide[alm_pkg::OWORD_BITS-1:0];
    assign res.count  = cnt_wide[alm_pkg::COUNT_BITS-1:0];

endmodule

/* sv/array_list_engine.sv */
// Array list engine: keeps a dense ordered list of words in a single-port-read,
// single-port-write synchronous RAM of CAPACITY entries, with its length in a
// register. Each request reads, writes or appends a word, removes the word at an
// index, or removes the first word equal to a given value, and returns one
// result with a status, the word read and the new length. A read waits for the
// registered RAM data before its result; write and append need no RAM read.
// Removal at index p and removal by value are paced by the one RAM read per
// cycle used to search and to move later words down. A result waits in an
// output register, and the next request is taken once the current one has
// been handed to it.
module array_list_engine #(
    parameter int unsigned CAPACITY  = 256,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_position,
    input  logic [31:0] s_word_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_word_out,
    output logic [8:0]  m_count_out
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    logic                 res_valid;
    logic                 res_ready;
    alm_pkg::result_t     res;
    logic [63:0]          word_wide;
    logic [WORD_BITS-1:0] word_cut;

    logic                 m_valid_reg, m_valid_next;
    alm_pkg::result_t     m_res_reg;

    // Incoming words are cut to the stored word width.
    assign word_wide = 64'(s_word_in);
    assign word_cut  = word_wide[WORD_BITS-1:0];

    alm_ctrl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .command     (s_command),
        .position    (s_position),
        .word        (word_cut),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    alm_store #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: takes a new result when empty or being emptied.
    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_res_reg.status;
    assign m_word_out  = m_res_reg.word;
    assign m_count_out = m_res_reg.count;

endmodule

/* sv/alm_checker.sv */
module alm_checker #(
    parameter int unsigned CAPACITY  = 256
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_word_out,
    input logic [8:0]  m_count_out
);

    // No result is offered in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A stalled result holds its fields.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_word_out)
            && $stable(m_count_out))
        else $error("stalled result changed");

    // The engine is not ready in the cycle after it takes a request.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while the previous one is in progress");

    // A failed command returns no word.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != alm_pkg::ST_OK) |-> (m_word_out == 32'd0))
        else $error("failed command returned a word");

    // The reported length never exceeds the capacity.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_count_out) <= CAPACITY))
        else $error("length beyond capacity");

endmodule

bind array_list_engine alm_checker #(
    .CAPACITY  (CAPACITY)
) u_alm_checker (.*);
